### rtl/core/lefr_pkg.sv
package lefr_pkg;

   localparam int Window      = 64;
   localparam int WindowLog   = $clog2(Window);
   localparam int EnergyWidth = 32;
   localparam int BoundWidth  = 16;
   localparam int SumWidth    = EnergyWidth + WindowLog;
   localparam int LimitWidth  = BoundWidth + SumWidth;
   localparam int ScaledShift = 8 + WindowLog;
   localparam int CountWidth  = $clog2(Window + 1);
   localparam int ScanWidth   = WindowLog;
   localparam int LowCountWidth = 7;
   localparam int RatioWidth  = 17;
   localparam int RatioShift  = 16 - WindowLog;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [EnergyWidth-1:0]   OneQ16      = 32'h0001_0000;
   localparam logic [SumWidth-1:0]      SumReset    = SumWidth'((Window / 2) * 65536);
   localparam logic [BoundWidth-1:0]    BoundReset  = 16'd128;
   localparam logic [ScanWidth-1:0]     ScanLast    = ScanWidth'(Window - 1);
   localparam logic [RatioWidth-1:0]    LowCountMax = 17'd127;
   localparam logic [CsrAddrWidth-3:0]  RegBoundFactor = '0;

   typedef enum logic [1:0] {
      StIdle,
      StMult,
      StScan,
      StEmit
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
   } tally_ctrl_type;

endpackage

### rtl/core/lefr_if.sv
interface lefr_req_if;
   logic                             valid;
   logic                             ready;
   logic [lefr_pkg::EnergyWidth-1:0] frame_energy;

   modport source (output valid, output frame_energy, input ready);
   modport sink (input valid, input frame_energy, output ready);
endinterface

interface lefr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lefr_pkg::LowCountWidth-1:0] low_count;
   logic [lefr_pkg::RatioWidth-1:0]    low_ratio;

   modport source (output valid, output low_count, output low_ratio, input ready);
   modport sink (input valid, input low_count, input low_ratio, output ready);
endinterface

### rtl/core/lefr_cell.sv
module lefr_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lefr_pkg::EnergyWidth-1:0] init_value,
   input  logic                             shift,
   input  logic [lefr_pkg::EnergyWidth-1:0] neighbor_entry,
   output logic [lefr_pkg::EnergyWidth-1:0] entry
);

   logic [lefr_pkg::EnergyWidth-1:0] entry_ff;
   logic [lefr_pkg::EnergyWidth-1:0] entry_in;

   assign entry_in = shift ? neighbor_entry : entry_ff;
   assign entry    = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= init_value;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/core/lefr_tally.sv
module lefr_tally (
   input  logic                             clock,
   input  logic                             reset,
   input  lefr_pkg::tally_ctrl_type         ctrl,
   input  logic [lefr_pkg::EnergyWidth-1:0] entry,
   input  logic [lefr_pkg::LimitWidth-1:0]  limit,
   output logic [lefr_pkg::CountWidth-1:0]  total
);

   logic [lefr_pkg::LimitWidth-1:0] scaled;
   logic                            hit;
   logic [lefr_pkg::CountWidth-1:0] count_ff;
   logic [lefr_pkg::CountWidth-1:0] count_in;

   // entry * 256 * Window, compared against bound * sum
   assign scaled = {{(lefr_pkg::LimitWidth - lefr_pkg::EnergyWidth - lefr_pkg::ScaledShift){1'b0}},
                    entry, {lefr_pkg::ScaledShift{1'b0}}};
   assign hit    = ctrl.step && (scaled < limit);

   always_comb begin
      if (ctrl.clear) begin
         count_in = '0;
      end else begin
         count_in = count_ff + {{(lefr_pkg::CountWidth-1){1'b0}}, hit};
      end
   end

   assign total = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/low_energy_frame_ratio_unit.sv
// Channel  | Direction | Payload
// req_chan | in        | frame_energy (32b, Q16.16)
// rsp_chan | out       | low_count (7b), low_ratio (17b, Q1.16)
// csr      | in        | APB, bound_factor at 0x0 (16b, Q8.8)
//
// Each item is shifted into the cell chain while the sum is updated, then the
// bound*sum multiply runs, then the chain rotates one cell per cycle past a
// single comparator across all cells. The next beat is taken once the result sits
// in the output register. Reset is synchronous and needs no clearing pass.
// A stalled result holds the block in its emit state until the register frees.
module low_energy_frame_ratio_unit (
   input  logic                              clock,
   input  logic                              reset,
   lefr_req_if.sink                          req_chan,
   lefr_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lefr_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [lefr_pkg::CsrDataWidth-1:0] pwdata,
   output logic [lefr_pkg::CsrDataWidth-1:0] prdata,
   output logic                              pready
);

   lefr_pkg::state_type state_ff;
   lefr_pkg::state_type state_in;

   logic [lefr_pkg::BoundWidth-1:0]  bound_ff;
   logic [lefr_pkg::BoundWidth-1:0]  bound_in;
   logic [lefr_pkg::SumWidth-1:0]    sum_ff;
   logic [lefr_pkg::SumWidth-1:0]    sum_in;
   logic [lefr_pkg::LimitWidth-1:0]  limit_ff;
   logic [lefr_pkg::LimitWidth-1:0]  limit_in;
   logic [lefr_pkg::ScanWidth-1:0]   scan_ff;
   logic [lefr_pkg::ScanWidth-1:0]   scan_in;

   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   logic [lefr_pkg::LowCountWidth-1:0] rsp_count_ff;
   logic [lefr_pkg::LowCountWidth-1:0] rsp_count_in;
   logic [lefr_pkg::RatioWidth-1:0]    rsp_ratio_ff;
   logic [lefr_pkg::RatioWidth-1:0]    rsp_ratio_in;

   logic                             accept;
   logic                             shift;
   logic                             load_rsp;
   logic                             rsp_free;
   logic                             scan_last;
   logic                             csr_hit;
   logic                             csr_write;
   lefr_pkg::tally_ctrl_type         tally_ctrl;
   logic [lefr_pkg::CountWidth-1:0]  total;
   logic [lefr_pkg::RatioWidth-1:0]  total_ext;
   logic [lefr_pkg::EnergyWidth-1:0] head_entry;
   logic [lefr_pkg::EnergyWidth-1:0] tail_entry;
   logic [lefr_pkg::EnergyWidth-1:0] cell_entry [lefr_pkg::Window];

   // csr
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[lefr_pkg::CsrAddrWidth-1:2] == lefr_pkg::RegBoundFactor);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;
   assign bound_in  = csr_write ? pwdata[lefr_pkg::BoundWidth-1:0] : bound_ff;
   assign prdata    = csr_hit ?
                      {{(lefr_pkg::CsrDataWidth-lefr_pkg::BoundWidth){1'b0}}, bound_ff} : '0;

   // cell chain; the last cell holds the oldest entry except while the scan rotates the chain
   assign tail_entry = cell_entry[lefr_pkg::Window-1];
   assign head_entry = accept ? req_chan.frame_energy : tail_entry;

   for (genvar j = 0; j < lefr_pkg::Window; j++) begin : g_cell
      localparam int Slot = lefr_pkg::Window - 1 - j;
      localparam logic [lefr_pkg::EnergyWidth-1:0] Init =
         (Slot % 2 == 1) ? lefr_pkg::OneQ16 : '0;
      if (j == 0) begin : g_head
         lefr_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .init_value     (Init),
            .shift          (shift),
            .neighbor_entry (head_entry),
            .entry          (cell_entry[j])
         );
      end else begin : g_body
         lefr_cell u_cell (
            .clock          (clock),
            .reset          (reset),
            .init_value     (Init),
            .shift          (shift),
            .neighbor_entry (cell_entry[j-1]),
            .entry          (cell_entry[j])
         );
      end
   end

   lefr_tally u_tally (
      .clock (clock),
      .reset (reset),
      .ctrl  (tally_ctrl),
      .entry (tail_entry),
      .limit (limit_ff),
      .total (total)
   );

   assign scan_last = (scan_ff == lefr_pkg::ScanLast);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lefr_pkg::StIdle: begin
            if (req_chan.valid) begin
               state_in = lefr_pkg::StMult;
            end
         end
         lefr_pkg::StMult: begin
            state_in = lefr_pkg::StScan;
         end
         lefr_pkg::StScan: begin
            if (scan_last) begin
               state_in = rsp_free ? lefr_pkg::StIdle : lefr_pkg::StEmit;
            end
         end
         lefr_pkg::StEmit: begin
            if (rsp_free) begin
               state_in = lefr_pkg::StIdle;
            end
         end
         default: begin
            state_in = lefr_pkg::StIdle;
         end
      endcase
   end

   // state outputs
   always_comb begin
      accept           = 1'b0;
      shift            = 1'b0;
      load_rsp         = 1'b0;
      tally_ctrl.clear = 1'b0;
      tally_ctrl.step  = 1'b0;
      case (state_ff)
         lefr_pkg::StIdle: begin
            accept = req_chan.valid;
            shift  = req_chan.valid;
         end
         lefr_pkg::StMult: begin
            tally_ctrl.clear = 1'b1;
         end
         lefr_pkg::StScan: begin
            shift           = 1'b1;
            tally_ctrl.step = 1'b1;
            load_rsp        = scan_last && rsp_free;
         end
         lefr_pkg::StEmit: begin
            load_rsp = rsp_free;
         end
         default: begin
            accept = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == lefr_pkg::StIdle);

   assign sum_in = accept ?
      sum_ff - {{lefr_pkg::WindowLog{1'b0}}, tail_entry}
             + {{lefr_pkg::WindowLog{1'b0}}, req_chan.frame_energy} : sum_ff;

   assign limit_in = (state_ff == lefr_pkg::StMult) ?
      {{lefr_pkg::SumWidth{1'b0}}, bound_ff} * {{lefr_pkg::BoundWidth{1'b0}}, sum_ff} : limit_ff;

   assign scan_in = (state_ff == lefr_pkg::StMult) ? '0 :
                    (state_ff == lefr_pkg::StScan) ? scan_ff + 1'b1 : scan_ff;

   // result
   assign total_ext = {{(lefr_pkg::RatioWidth-lefr_pkg::CountWidth){1'b0}}, total};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ratio_in = rsp_ratio_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = (total_ext > lefr_pkg::LowCountMax) ?
                        lefr_pkg::LowCountMax[lefr_pkg::LowCountWidth-1:0] :
                        total_ext[lefr_pkg::LowCountWidth-1:0];
         rsp_ratio_in = total_ext << lefr_pkg::RatioShift;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.low_count = rsp_count_ff;
   assign rsp_chan.low_ratio = rsp_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lefr_pkg::StIdle;
         bound_ff     <= lefr_pkg::BoundReset;
         sum_ff       <= lefr_pkg::SumReset;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bound_ff     <= bound_in;
         sum_ff       <= sum_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ratio_ff <= rsp_ratio_in;
   end

endmodule
